// ----- sv/sbls_pkg.sv -----
package sbls_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_COLOR_A_RED   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_A_GREEN = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_A_BLUE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_B_RED   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_B_GREEN = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_B_BLUE  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_LEDS      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SYMMETRIC     = 4'd7;

    localparam int unsigned NUM_CH = 3;

    // Reciprocal of 15 in 16-bit fixed point, exact for products up to 15*255
    localparam logic [12:0] RECIP_15 = 13'd4370;

    typedef struct packed {
        logic [3:0] band;
        logic [7:0] level;
    } in_t;

    typedef struct packed {
        logic [9:0] led_index;
        logic [9:0] mirror_index;
        logic       mirror_valid;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [NUM_CH-1:0][7:0] color_a;
        logic [NUM_CH-1:0][7:0] color_b;
        logic [10:0]            num_leds;
        logic                   symmetric;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic quo;
        logic blend;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic width_zero;
        logic at_last;
    } stat_t;

    // x/255 for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

// ----- sv/sbls_regs.sv -----
module sbls_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [sbls_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [sbls_pkg::CFG_DATA_W-1:0]     wr_data,
    output sbls_pkg::cfg_t                      cfg
);

    sbls_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_a[0] <= 8'd0;
            cfg_reg.color_a[1] <= 8'd0;
            cfg_reg.color_a[2] <= 8'd0;
            cfg_reg.color_b[0] <= 8'd255;
            cfg_reg.color_b[1] <= 8'd0;
            cfg_reg.color_b[2] <= 8'd0;
            cfg_reg.num_leds   <= 11'd0;
            cfg_reg.symmetric  <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                sbls_pkg::REG_COLOR_A_RED:   cfg_reg.color_a[0] <= wr_data[7:0];
                sbls_pkg::REG_COLOR_A_GREEN: cfg_reg.color_a[1] <= wr_data[7:0];
                sbls_pkg::REG_COLOR_A_BLUE:  cfg_reg.color_a[2] <= wr_data[7:0];
                sbls_pkg::REG_COLOR_B_RED:   cfg_reg.color_b[0] <= wr_data[7:0];
                sbls_pkg::REG_COLOR_B_GREEN: cfg_reg.color_b[1] <= wr_data[7:0];
                sbls_pkg::REG_COLOR_B_BLUE:  cfg_reg.color_b[2] <= wr_data[7:0];
                sbls_pkg::REG_NUM_LEDS:      cfg_reg.num_leds   <= wr_data[10:0];
                sbls_pkg::REG_SYMMETRIC:     cfg_reg.symmetric  <= wr_data[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/sbls_ctrl.sv -----
module sbls_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  sbls_pkg::stat_t stat,
    output sbls_pkg::cmd_t  cmd,
    output logic            busy
);

    typedef enum logic [2:0] {
        IDLE,
        MUL,
        QUO,
        BLEND,
        EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            IDLE:    if (start) state_next = MUL;
            MUL:     state_next = QUO;
            QUO:     state_next = BLEND;
            BLEND:   state_next = stat.width_zero ? IDLE : EMIT;
            EMIT:    if (stat.at_last) state_next = IDLE;
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != IDLE);
        end
    end

    assign cmd.load  = (state_reg == IDLE) && start;
    assign cmd.mul   = (state_reg == MUL);
    assign cmd.quo   = (state_reg == QUO);
    assign cmd.blend = (state_reg == BLEND);
    assign cmd.emit  = (state_reg == EMIT);
    assign busy      = busy_reg;

endmodule

// ----- sv/sbls_dp.sv -----
module sbls_dp #(
    parameter int unsigned MAX_LEDS = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  sbls_pkg::cmd_t  cmd,
    input  sbls_pkg::in_t   item,
    input  sbls_pkg::cfg_t  cfg,
    output sbls_pkg::stat_t stat,
    output sbls_pkg::out_t  result,
    output logic            strobe
);

    localparam int unsigned CNT_W = $clog2(MAX_LEDS / 16 + 1);
    localparam logic [10:0] MAX_N = 11'(MAX_LEDS);

    logic [3:0]       band_reg;
    logic [7:0]       level_reg;
    logic [10:0]      n_reg;
    logic             sym_reg;
    logic [CNT_W-1:0] width_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [9:0]       base_reg;
    logic [15:0]      prod_a_reg [sbls_pkg::NUM_CH];
    logic [15:0]      prod_b_reg [sbls_pkg::NUM_CH];
    logic [11:0]      part_a_reg [sbls_pkg::NUM_CH];
    logic [11:0]      part_b_reg [sbls_pkg::NUM_CH];
    logic [7:0]       color_reg  [sbls_pkg::NUM_CH];
    sbls_pkg::out_t   result_reg;
    logic             strobe_reg;

    logic [10:0]      n_clamp;
    logic [9:0]       led;
    logic [25:0]      lo_full [sbls_pkg::NUM_CH];
    logic [25:0]      hi_full [sbls_pkg::NUM_CH];
    logic [7:0]       blend   [sbls_pkg::NUM_CH];

    assign n_clamp = (cfg.num_leds > MAX_N) ? MAX_N : cfg.num_leds;
    assign led     = base_reg + 10'(cnt_reg);

    always_comb
    begin
        for (int c = 0; c < sbls_pkg::NUM_CH; c++)
        begin
            lo_full[c] = 26'(part_a_reg[c]) * 26'(sbls_pkg::RECIP_15);
            hi_full[c] = 26'(part_b_reg[c]) * 26'(sbls_pkg::RECIP_15);
            blend[c]   = lo_full[c][23:16] + hi_full[c][23:16];
        end
    end

    // Payload pipeline, advanced by the controller
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            band_reg  <= item.band;
            level_reg <= item.level;
            n_reg     <= n_clamp;
            sym_reg   <= cfg.symmetric;
            width_reg <= cfg.symmetric ? CNT_W'(n_clamp >> 5) : CNT_W'(n_clamp >> 4);
        end
        if (cmd.mul)
        begin
            for (int c = 0; c < sbls_pkg::NUM_CH; c++)
            begin
                prod_a_reg[c] <= 16'(cfg.color_a[c]) * 16'(level_reg);
                prod_b_reg[c] <= 16'(cfg.color_b[c]) * 16'(level_reg);
            end
            base_reg <= 10'(band_reg) * 10'(width_reg);
        end
        if (cmd.quo)
        begin
            for (int c = 0; c < sbls_pkg::NUM_CH; c++)
            begin
                part_a_reg[c] <= 12'(sbls_pkg::div255(prod_a_reg[c])) * 12'(4'd15 - band_reg);
                part_b_reg[c] <= 12'(sbls_pkg::div255(prod_b_reg[c])) * 12'(band_reg);
            end
        end
        if (cmd.blend)
        begin
            for (int c = 0; c < sbls_pkg::NUM_CH; c++)
                color_reg[c] <= blend[c];
        end
        if (cmd.emit)
        begin
            result_reg.led_index    <= led;
            result_reg.mirror_index <= sym_reg ? 10'(n_reg - 11'd1 - 11'(led)) : 10'd0;
            result_reg.mirror_valid <= sym_reg;
            result_reg.red          <= color_reg[0];
            result_reg.green        <= color_reg[1];
            result_reg.blue         <= color_reg[2];
            result_reg.last         <= stat.at_last;
        end
    end

    // Offset within the stripe and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
            if (cmd.load)
                cnt_reg <= '0;
            else if (cmd.emit)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign stat.width_zero = (width_reg == '0);
    assign stat.at_last    = (cnt_reg == width_reg - 1'b1);
    assign result          = result_reg;
    assign strobe          = strobe_reg;

endmodule

// ----- sv/spectrum_bar_led_shader.sv -----
// A taken request runs the multiply, divide and blend states; each LED write is then
// registered from the emit state, one per cycle, W writes per band; busy is high until done.
// W = stripe width (num_leds/16, or /32 symmetric, up to 64), taken at the request.
// A band with an empty stripe drops busy after the blend state and gives no write.
// The receiver cannot stall: each write is shown for one cycle with strobe high.
// Reset (rst_n, async, active low) clears control and loads register defaults.
module spectrum_bar_led_shader #(
    parameter int unsigned MAX_LEDS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request side
    input  logic                            start,
    output logic                            busy,
    input  sbls_pkg::in_t                   item,
    // LED write side
    output sbls_pkg::out_t                  result,
    output logic                            strobe,
    // configuration writes
    input  logic                            wr_en,
    input  logic [sbls_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [sbls_pkg::CFG_DATA_W-1:0] wr_data
);

    sbls_pkg::cfg_t  cfg;
    sbls_pkg::cmd_t  cmd;
    sbls_pkg::stat_t stat;

    // Colour, strip length and mirror mode
    sbls_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // Sequencer: multiply, divide, blend, then walk the stripe
    sbls_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Colour arithmetic and LED index generation
    sbls_dp #(
        .MAX_LEDS (MAX_LEDS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .cfg    (cfg),
        .stat   (stat),
        .result (result),
        .strobe (strobe)
    );

endmodule

// ----- tb/sv/led_write_checker.sv -----
module led_write_checker #(
    parameter int unsigned MAX_LEDS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  sbls_pkg::in_t                   item,
    input  sbls_pkg::out_t                  result,
    input  logic                            strobe,
    input  logic                            wr_en,
    input  logic [sbls_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [sbls_pkg::CFG_DATA_W-1:0] wr_data,
    output int unsigned                     errors,
    output int unsigned                     pending
);

    localparam int unsigned LEVEL_FULL = 255;
    localparam int unsigned TOP_BAND   = 15;
    localparam int unsigned MAX_SPAN   = 64;

    // shadow of the block's registers
    logic [7:0]  col_lo [sbls_pkg::NUM_CH];
    logic [7:0]  col_hi [sbls_pkg::NUM_CH];
    logic [10:0] strip_len;
    logic        mirrored;

    sbls_pkg::out_t led_writes_due [$];

    // per-channel blend, truncating at every division
    function automatic logic [7:0] blend(input logic [7:0] lo_col, input logic [7:0] hi_col,
                                         input logic [7:0] level, input logic [3:0] band);
        int unsigned ca, cb, lv, bd;
        ca = lo_col;
        cb = hi_col;
        lv = level;
        bd = band;
        return 8'((ca * lv / LEVEL_FULL * (TOP_BAND - bd)) / TOP_BAND
                  + (cb * lv / LEVEL_FULL * bd) / TOP_BAND);
    endfunction

    task automatic queue_stripe(input sbls_pkg::in_t req);
        int unsigned n, span, led;
        sbls_pkg::out_t w;
        n = (strip_len > MAX_LEDS) ? MAX_LEDS : strip_len;
        span = mirrored ? n / 32 : n / 16;
        if (span > MAX_SPAN)
            span = MAX_SPAN;
        w.red   = blend(col_lo[0], col_hi[0], req.level, req.band);
        w.green = blend(col_lo[1], col_hi[1], req.level, req.band);
        w.blue  = blend(col_lo[2], col_hi[2], req.level, req.band);
        for (int unsigned j = 0; j < span; j++)
        begin
            led = req.band * span + j;
            w.led_index    = 10'(led);
            w.mirror_index = mirrored ? 10'(n - 1 - led) : '0;
            w.mirror_valid = mirrored;
            w.last         = (j + 1 == span);
            led_writes_due.push_back(w);
        end
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        sbls_pkg::out_t due;
        if (!rst_n)
        begin
            col_lo    = '{8'd0, 8'd0, 8'd0};
            col_hi    = '{8'd255, 8'd0, 8'd0};
            strip_len = '0;
            mirrored  = 1'b0;
            led_writes_due.delete();
            errors    = 0;
        end
        else
        begin
            if (strobe)
            begin
                if (led_writes_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: LED write %0d with none expected", $time, result.led_index);
                end
                else
                begin
                    due = led_writes_due.pop_front();
                    check_field("led_index", due.led_index, result.led_index);
                    check_field("mirror_index", due.mirror_index, result.mirror_index);
                    check_field("mirror_valid", due.mirror_valid, result.mirror_valid);
                    check_field("red", due.red, result.red);
                    check_field("green", due.green, result.green);
                    check_field("blue", due.blue, result.blue);
                    check_field("last", due.last, result.last);
                end
            end
            if (start && !busy)
                queue_stripe(item);
            if (wr_en)
            begin
                case (wr_index)
                    sbls_pkg::REG_COLOR_A_RED:   col_lo[0] = wr_data[7:0];
                    sbls_pkg::REG_COLOR_A_GREEN: col_lo[1] = wr_data[7:0];
                    sbls_pkg::REG_COLOR_A_BLUE:  col_lo[2] = wr_data[7:0];
                    sbls_pkg::REG_COLOR_B_RED:   col_hi[0] = wr_data[7:0];
                    sbls_pkg::REG_COLOR_B_GREEN: col_hi[1] = wr_data[7:0];
                    sbls_pkg::REG_COLOR_B_BLUE:  col_hi[2] = wr_data[7:0];
                    sbls_pkg::REG_NUM_LEDS:      strip_len = wr_data;
                    sbls_pkg::REG_SYMMETRIC:     mirrored  = wr_data[0];
                    default: ;
                endcase
            end
        end
        pending = led_writes_due.size();
    end

endmodule

// ----- tb/sv/spectrum_bar_led_shader_test.sv -----
module spectrum_bar_led_shader_test;

    // 8 defined registers; anything from here to the top of the index range is unused
    localparam int unsigned NUM_REGS  = 8;
    localparam int unsigned LAST_IDX  = (1 << sbls_pkg::CFG_IDX_W) - 1;
    // settle margin past the request, covering the first write and an empty stripe
    localparam int unsigned DRAIN     = 16;
    localparam int unsigned PHASES    = 8;
    localparam int unsigned PER_PHASE = 60;
    localparam int unsigned MAX_IDLE  = 18;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    sbls_pkg::in_t                   item = '0;
    sbls_pkg::out_t                  result;
    logic                            strobe;
    logic                            wr_en = 1'b0;
    logic [sbls_pkg::CFG_IDX_W-1:0]  wr_index = '0;
    logic [sbls_pkg::CFG_DATA_W-1:0] wr_data = '0;

    int unsigned errors;
    int unsigned pending;
    // longest gap the request side may leave before the next request; 0 = back to back
    int unsigned idle_max = MAX_IDLE;

    always #2 clk = ~clk;

    spectrum_bar_led_shader dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .result   (result),
        .strobe   (strobe),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    led_write_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .result   (result),
        .strobe   (strobe),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .errors   (errors),
        .pending  (pending)
    );

    // One band request. Start is only lowered when an idle gap is drawn, so a
    // back-to-back request keeps it high with a single assignment per edge.
    task automatic request_band(input logic [3:0] band, input logic [7:0] level);
        sbls_pkg::in_t req;
        int unsigned gap;
        gap = $urandom_range(0, idle_max);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.band  = band;
        req.level = level;
        item  <= req;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Bring the block to rest: the first wait covers the edge at which the last
    // request was taken, before busy and the checker's queue have caught up.
    task automatic settle();
        start <= 1'b0;
        repeat (DRAIN) @(posedge clk);
        while (busy || pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic set_reg(input logic [sbls_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sbls_pkg::CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
    endtask

    // Full register load plus one write to an unused index, which must change nothing.
    // Upper data bits beyond a register's width are passed as given.
    task automatic setup(input logic [10:0] a_r, input logic [10:0] a_g, input logic [10:0] a_b,
                         input logic [10:0] b_r, input logic [10:0] b_g, input logic [10:0] b_b,
                         input logic [10:0] leds, input logic [10:0] sym);
        set_reg(sbls_pkg::REG_COLOR_A_RED,   a_r);
        set_reg(sbls_pkg::REG_COLOR_A_GREEN, a_g);
        set_reg(sbls_pkg::REG_COLOR_A_BLUE,  a_b);
        set_reg(sbls_pkg::REG_COLOR_B_RED,   b_r);
        set_reg(sbls_pkg::REG_COLOR_B_GREEN, b_g);
        set_reg(sbls_pkg::REG_COLOR_B_BLUE,  b_b);
        set_reg(sbls_pkg::REG_NUM_LEDS,      leds);
        set_reg(sbls_pkg::REG_SYMMETRIC,     sym);
        set_reg(sbls_pkg::CFG_IDX_W'($urandom_range(NUM_REGS, LAST_IDX)),
                sbls_pkg::CFG_DATA_W'($urandom_range(0, 2047)));
        wr_en <= 1'b0;
    endtask

    // colours lean on the extremes; random picks also carry junk in bits 10:8
    function automatic logic [10:0] pick_colour();
        case ($urandom_range(0, 3))
            0:       return 11'd0;
            1:       return 11'd255;
            default: return 11'($urandom_range(0, 2047));
        endcase
    endfunction

    // strip lengths: mostly modest, now and then empty, exact or beyond the maximum
    function automatic logic [10:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return 11'($urandom_range(0, 31));
            1:       return 11'd32;
            2:       return 11'd1024;
            3:       return 11'($urandom_range(1025, 2047));
            4:       return 11'd2047;
            default: return 11'($urandom_range(16, 400));
        endcase
    endfunction

    initial
    begin : stimulus
        logic [7:0] level;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset values leave the strip empty: requests taken, nothing written
        request_band(4'd0, 8'd255);
        request_band(4'd15, 8'd255);
        settle();

        // full strip, plain mode: band and level extremes, mid-scale blends
        setup(11'd255, 11'd0, 11'd128, 11'd0, 11'd255, 11'd255, 11'd1024, 11'd0);
        request_band(4'd0, 8'd255);
        request_band(4'd15, 8'd255);
        request_band(4'd0, 8'd0);
        request_band(4'd15, 8'd0);
        request_band(4'd7, 8'd128);
        request_band(4'd8, 8'd1);
        request_band(4'd5, 8'd200);
        settle();

        // mirrored half-width stripes across the full strip
        setup(11'd255, 11'd0, 11'd128, 11'd0, 11'd255, 11'd255, 11'd1024, 11'd1);
        request_band(4'd0, 8'd255);
        request_band(4'd15, 8'd255);
        request_band(4'd9, 8'd77);
        settle();

        // strip length beyond the maximum is clipped, with and without mirroring
        setup(11'd255, 11'd255, 11'd255, 11'd255, 11'd255, 11'd255, 11'd2047, 11'd0);
        request_band(4'd15, 8'd255);
        request_band(4'd3, 8'd254);
        settle();
        setup(11'd255, 11'd255, 11'd255, 11'd255, 11'd255, 11'd255, 11'd1040, 11'd1);
        request_band(4'd15, 8'd100);
        settle();

        // just below and just at one LED per stripe
        setup(11'd10, 11'd20, 11'd30, 11'd40, 11'd50, 11'd60, 11'd15, 11'd0);
        request_band(4'd4, 8'd99);
        settle();
        setup(11'd10, 11'd20, 11'd30, 11'd40, 11'd50, 11'd60, 11'd31, 11'd1);
        request_band(4'd4, 8'd99);
        settle();
        setup(11'd10, 11'd20, 11'd30, 11'd40, 11'd50, 11'd60, 11'd32, 11'd1);
        request_band(4'd0, 8'd255);
        request_band(4'd15, 8'd255);
        settle();
        setup(11'd10, 11'd20, 11'd30, 11'd40, 11'd50, 11'd60, 11'd16, 11'd0);
        request_band(4'd15, 8'd128);
        settle();

        // random phases; every third runs requests back to back
        for (int unsigned phase = 0; phase < PHASES; phase++)
        begin
            setup(pick_colour(), pick_colour(), pick_colour(),
                  pick_colour(), pick_colour(), pick_colour(),
                  pick_length(), 11'($urandom_range(0, 2047)));
            idle_max = (phase % 3 == 1) ? 0 : MAX_IDLE;
            for (int unsigned k = 0; k < PER_PHASE; k++)
            begin
                case ($urandom_range(0, 7))
                    0:       level = 8'd0;
                    1:       level = 8'd255;
                    default: level = 8'($urandom_range(0, 255));
                endcase
                request_band(4'($urandom_range(0, 15)), level);
            end
            settle();
        end

        if (pending != 0)
            $display("%0t: %0d LED writes never appeared", $time, pending);
        if (errors == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog, several times the slowest correct run
    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- spectrum_bar_led_shader.f -----
sv/sbls_pkg.sv
sv/sbls_regs.sv
sv/sbls_ctrl.sv
sv/sbls_dp.sv
sv/spectrum_bar_led_shader.sv
tb/sv/led_write_checker.sv
tb/sv/spectrum_bar_led_shader_test.sv
